// ===== rtl/urs_pkg.sv =====
// ----------------------------------------------------------------------------
// urs_pkg: shared types and constants for the ultrasonic ranger display
// Register codes, ranging phases, the tick record passed from the ranging
// front end to the display back end, and the seven-segment decode.
// ----------------------------------------------------------------------------
package urs_pkg;

	// display geometry
	localparam int DIGITS  = 4;
	localparam int SCAN_W  = 2;
	localparam int DIG_W   = 4;
	localparam int SEG_W   = 8;

	// register and counter widths
	localparam int PERIOD_W = 16;
	localparam int TRIG_W   = 8;
	localparam int DWELL_W  = 16;
	localparam int TOUT_W   = 20;
	localparam int DIST_W   = 14;
	localparam int CFG_AW   = 3;

	// saturation value of the 20 bit phase and width counters
	localparam logic [TOUT_W-1:0] LIMIT20 = 20'hFFFFF;

	// distance conversion: mm = floor(width * 343 / 2000), clamped to 9999
	localparam logic [8:0]        SOUND_MUL  = 9'd343;
	localparam logic [DIST_W-1:0] MAX_MM     = 14'd9999;
	// smallest width whose distance exceeds the clamp
	localparam logic [TOUT_W-1:0] CLAMP_W    = 20'd58310;
	// ceil(2^28 / 125), exact for quotients of values below 2^21
	localparam logic [21:0]       RECIP_125  = 22'd2147484;

	// reset values of the registers
	localparam logic [PERIOD_W-1:0] PERIOD_RST  = 16'd50000;
	localparam logic [TRIG_W-1:0]   TRIGGER_RST = 8'd10;
	localparam logic [DWELL_W-1:0]  DWELL_RST   = 16'd1000;
	localparam logic [TOUT_W-1:0]   TIMEOUT_RST = 20'd1000000;

	// register indexes on the write port
	typedef enum logic [CFG_AW-1:0] {
		REG_PERIOD  = 3'd0,
		REG_TRIGGER = 3'd1,
		REG_DWELL   = 3'd2,
		REG_TIMEOUT = 3'd3
	} reg_idx_t;

	// ranging phases
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_TRIG,
		PH_WAIT,
		PH_HIGH
	} phase_t;

	// ranging settings used by the front end
	typedef struct packed {
		logic [PERIOD_W-1:0] period;
		logic [TRIG_W-1:0]   trigger;
		logic [TOUT_W-1:0]   timeout;
	} range_cfg_t;

	// one classified tick: trigger level, store flag and measured width
	typedef struct packed {
		logic              trig;
		logic              done;
		logic [TOUT_W-1:0] width;
	} tick_rec_t;

	// segment pattern, bit0 A through bit6 G, DP off
	function automatic logic [SEG_W-1:0] seg_decode(input logic [DIG_W-1:0] d);
		logic [SEG_W-1:0] s;
		unique case (d)
			4'd0:    s = 8'h3F;
			4'd1:    s = 8'h06;
			4'd2:    s = 8'h5B;
			4'd3:    s = 8'h4F;
			4'd4:    s = 8'h66;
			4'd5:    s = 8'h6D;
			4'd6:    s = 8'h7D;
			4'd7:    s = 8'h07;
			4'd8:    s = 8'h7F;
			4'd9:    s = 8'h6F;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/ultrasonic_range_seven_segment_display_top.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_range_seven_segment_display_top: ultrasonic ranger with display
// One input word is one microsecond tick with the echo level. The block
// triggers a measurement every period, times the echo pulse, converts it to
// millimetres and scans the value onto a four-digit seven-segment display.
//
//   channel   dir  handshake          payload
//   s_*       in   s_tvalid/s_tready  s_tdata[0] echo_level
//   m_*       out  m_tvalid/m_tready  m_tdata: trigger, enables, segments,
//                                     distance, measure_done
//   cfg_*     in   cfg_we             cfg_addr register index, cfg_wdata
//
// One tick word is accepted per clock and one result word leaves per clock
// while neither side stalls. The tick record enters the queue on the
// accepting edge, then passes through the four conversion stages and the
// output register.
// The queue and the output register let either side stall; s_tready drops
// only when the queue is full. Reset clears all control and display state
// at once, with no clearing pass.
// ----------------------------------------------------------------------------
module ultrasonic_range_seven_segment_display_top
	import urs_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
)
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,    // [0] echo_level, [7:1] zero
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata,    // [0] trigger_level, [4:1] digit_enable_n,
	                                      // [12:5] segment_bits, [26:13] distance_mm,
	                                      // [27] measure_done, [31:28] zero
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [TOUT_W-1:0] cfg_wdata
);

	logic [PERIOD_W-1:0] period_q;
	logic [TRIG_W-1:0]   trigger_q;
	logic [DWELL_W-1:0]  dwell_q;
	logic [TOUT_W-1:0]   timeout_q;
	range_cfg_t          range_cfg;

	logic      front_valid, front_ready;
	tick_rec_t front_rec;
	logic      back_valid, back_ready;
	tick_rec_t back_rec;

	logic              out_trig, out_done;
	logic [DIGITS-1:0] out_enable_n;
	logic [SEG_W-1:0]  out_seg;
	logic [DIST_W-1:0] out_dist;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= PERIOD_RST;
			trigger_q <= TRIGGER_RST;
			dwell_q   <= DWELL_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_PERIOD:  period_q  <= cfg_wdata[PERIOD_W-1:0];
				REG_TRIGGER: trigger_q <= cfg_wdata[TRIG_W-1:0];
				REG_DWELL:   dwell_q   <= cfg_wdata[DWELL_W-1:0];
				REG_TIMEOUT: timeout_q <= cfg_wdata;
				default:     ;
			endcase
		end
	end

	assign range_cfg.period  = period_q;
	assign range_cfg.trigger = trigger_q;
	assign range_cfg.timeout = timeout_q;

	// ranging front end
	urs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (range_cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.echo      (s_tdata[0]),
		.rec_valid (front_valid),
		.rec_ready (front_ready),
		.rec       (front_rec)
	);

	// tick record queue
	urs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_rec   (front_rec),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_rec    (back_rec)
	);

	// conversion and display back end
	urs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.dwell        (dwell_q),
		.rec_valid    (back_valid),
		.rec_ready    (back_ready),
		.rec          (back_rec),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_trig     (out_trig),
		.out_enable_n (out_enable_n),
		.out_seg      (out_seg),
		.out_dist     (out_dist),
		.out_done     (out_done)
	);

	// output word packing
	assign m_tdata = {4'b0000, out_done, out_dist, out_seg, out_enable_n, out_trig};

endmodule

// ===== rtl/urs_front.sv =====
// ----------------------------------------------------------------------------
// urs_front: ranging front end
// Runs the period counter and the trigger / echo state machine on each
// accepted tick and emits one tick record per tick into the queue.
// ----------------------------------------------------------------------------
module urs_front
	import urs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  range_cfg_t cfg,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       echo,
	output logic       rec_valid,
	input  logic       rec_ready,
	output tick_rec_t  rec
);

	phase_t              phase_q, phase_d;
	logic [PERIOD_W-1:0] period_cnt_q, period_cnt_d;
	logic [TOUT_W-1:0]   phase_cnt_q, phase_cnt_d;
	logic [TOUT_W-1:0]   width_q, width_d;

	logic [PERIOD_W-1:0] per;
	logic [TRIG_W-1:0]   tlen;
	logic [TOUT_W-1:0]   tout;
	logic [PERIOD_W:0]   period_inc;
	logic [TOUT_W-1:0]   phase_inc;
	logic [TOUT_W-1:0]   phase_sat;
	logic                start;
	logic                timed_out;
	logic                take;

	// a word moves straight on into the queue
	assign in_ready  = rec_ready;
	assign rec_valid = in_valid;
	assign take      = in_valid && rec_ready;

	// zero settings behave as one
	assign per  = (cfg.period == '0)  ? PERIOD_W'(1) : cfg.period;
	assign tlen = (cfg.trigger == '0) ? TRIG_W'(1)   : cfg.trigger;
	assign tout = (cfg.timeout == '0) ? TOUT_W'(1)   : cfg.timeout;

	assign start      = (period_cnt_q == '0);
	assign period_inc = {1'b0, period_cnt_q} + (PERIOD_W+1)'(1);
	assign phase_inc  = phase_cnt_q + TOUT_W'(1);
	assign phase_sat  = (phase_cnt_q < LIMIT20) ? phase_inc : phase_cnt_q;
	assign timed_out  = (phase_sat >= tout);

	// next state and counters
	always_comb begin
		phase_d      = phase_q;
		phase_cnt_d  = phase_cnt_q;
		width_d      = width_q;
		period_cnt_d = (period_inc >= {1'b0, per}) ? '0 : period_inc[PERIOD_W-1:0];
		unique case (phase_q)
			PH_IDLE: begin
				if (start) begin
					if (tlen <= TRIG_W'(1)) begin
						phase_d     = PH_WAIT;
						phase_cnt_d = '0;
					end else begin
						phase_d     = PH_TRIG;
						phase_cnt_d = TOUT_W'(1);
					end
				end
			end
			PH_TRIG: begin
				phase_cnt_d = phase_inc;
				if (phase_inc >= TOUT_W'(tlen)) begin
					phase_d     = PH_WAIT;
					phase_cnt_d = '0;
				end
			end
			PH_WAIT: begin
				phase_cnt_d = phase_sat;
				if (echo) begin
					phase_d = PH_HIGH;
					width_d = TOUT_W'(1);
				end
				if (timed_out) begin
					phase_d = PH_IDLE;
				end
			end
			PH_HIGH: begin
				phase_cnt_d = phase_sat;
				priority if (!echo || timed_out) begin
					phase_d = PH_IDLE;
				end else if (width_q < LIMIT20) begin
					width_d = width_q + TOUT_W'(1);
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	// tick record for the back end
	always_comb begin
		rec.trig  = 1'b0;
		rec.done  = 1'b0;
		rec.width = '0;
		unique case (phase_q)
			PH_IDLE: rec.trig = start;
			PH_TRIG: rec.trig = 1'b1;
			PH_WAIT: rec.done = timed_out;
			PH_HIGH: begin
				rec.done = !echo || timed_out;
				if (!echo) begin
					rec.width = width_q;
				end
			end
			default: rec.trig = 1'b0;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			period_cnt_q <= '0;
			phase_cnt_q  <= '0;
			width_q      <= '0;
		end else if (take) begin
			phase_q      <= phase_d;
			period_cnt_q <= period_cnt_d;
			phase_cnt_q  <= phase_cnt_d;
			width_q      <= width_d;
		end
	end

endmodule

// ===== rtl/urs_queue.sv =====
// ----------------------------------------------------------------------------
// urs_queue: tick record queue
// Short first-in first-out buffer between the ranging front end and the
// display back end so that either side can stall on its own.
// ----------------------------------------------------------------------------
module urs_queue
	import urs_pkg::*;
#(
	parameter int DEPTH = 4
)
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  tick_rec_t push_rec,
	output logic      pop_valid,
	input  logic      pop_ready,
	output tick_rec_t pop_rec
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tick_rec_t         slot_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_rec    = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_rec;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/urs_back.sv =====
// ----------------------------------------------------------------------------
// urs_back: distance conversion and display back end
// Converts each stored echo width to millimetres and decimal digits over
// four pipeline stages, then runs the digit scan and drives the output word.
// ----------------------------------------------------------------------------
module urs_back
	import urs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [DWELL_W-1:0]  dwell,
	input  logic                rec_valid,
	output logic                rec_ready,
	input  tick_rec_t           rec,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                out_trig,
	output logic [DIGITS-1:0]   out_enable_n,
	output logic [SEG_W-1:0]    out_seg,
	output logic [DIST_W-1:0]   out_dist,
	output logic                out_done
);

	// leading decimal digit of v for a digit weight of unit
	function automatic logic [DIG_W-1:0] lead_digit(input logic [DIST_W-1:0] v,
			input logic [DIST_W-1:0] unit);
		logic [DIG_W-1:0] d;
		d = '0;
		for (int k = 1; k <= 9; k++) begin
			if (v >= DIST_W'(k) * unit) begin
				d = DIG_W'(k);
			end
		end
		return d;
	endfunction

	logic adv;

	// stage 1: width times speed
	logic              valid_s1, trig_s1, done_s1, clamp_s1;
	logic [28:0]       prod_s1;
	// stage 2: divide by 2000 and clamp
	logic              valid_s2, trig_s2, done_s2;
	logic [DIST_W-1:0] mm_s2;
	logic [42:0]       recip_prod;
	// stage 3: thousands digit
	logic              valid_s3, trig_s3, done_s3;
	logic [DIST_W-1:0] mm_s3, rem_s3;
	logic [DIG_W-1:0]  thou_s3, thou_c;
	// stage 4: hundreds digit
	logic              valid_s4, trig_s4, done_s4;
	logic [DIST_W-1:0] mm_s4, rem_s4;
	logic [DIG_W-1:0]  thou_s4, hund_s4, hund_c;

	// display state
	logic [DIG_W-1:0]   digit_q [DIGITS];
	logic [DIST_W-1:0]  dist_q;
	logic [SCAN_W-1:0]  scan_q;
	logic [DWELL_W-1:0] dwell_cnt_q;

	// output register
	logic               out_valid_q, out_trig_q, out_done_q;
	logic [DIGITS-1:0]  out_enable_n_q;
	logic [SEG_W-1:0]   out_seg_q;
	logic [DIST_W-1:0]  out_dist_q;

	// final stage logic
	logic [DIG_W-1:0]   tens_c, ones_c;
	logic [DIG_W-1:0]   new_digit [DIGITS];
	logic [DIG_W-1:0]   shown;
	logic [DWELL_W-1:0] dwell_lim, dwell_inc;
	logic               dwell_wrap;

	// whole pipeline moves when the output register is free
	assign adv       = !out_valid_q || out_ready;
	assign rec_ready = adv;

	assign recip_prod = 43'(prod_s1[24:4]) * 43'(RECIP_125);
	assign thou_c     = lead_digit(mm_s2, DIST_W'(1000));
	assign hund_c     = lead_digit(rem_s3, DIST_W'(100));
	assign tens_c     = lead_digit(rem_s4, DIST_W'(10));
	assign ones_c     = DIG_W'(rem_s4 - DIST_W'(tens_c) * DIST_W'(10));

	// digits after this word's store
	always_comb begin
		new_digit[0] = done_s4 ? thou_s4 : digit_q[0];
		new_digit[1] = done_s4 ? hund_s4 : digit_q[1];
		new_digit[2] = done_s4 ? tens_c  : digit_q[2];
		new_digit[3] = done_s4 ? ones_c  : digit_q[3];
	end
	assign shown = new_digit[scan_q];

	// dwell counter step
	assign dwell_lim  = (dwell == '0) ? DWELL_W'(1) : dwell;
	assign dwell_inc  = dwell_cnt_q + DWELL_W'(1);
	assign dwell_wrap = (dwell_inc >= dwell_lim) || (dwell_inc == '0);

	// conversion pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			trig_s1  <= rec.trig;
			done_s1  <= rec.done;
			clamp_s1 <= (rec.width >= CLAMP_W);
			prod_s1  <= 29'(rec.width) * 29'(SOUND_MUL);

			trig_s2 <= trig_s1;
			done_s2 <= done_s1;
			mm_s2   <= clamp_s1 ? MAX_MM : recip_prod[41:28];

			trig_s3 <= trig_s2;
			done_s3 <= done_s2;
			mm_s3   <= mm_s2;
			thou_s3 <= thou_c;
			rem_s3  <= mm_s2 - DIST_W'(thou_c) * DIST_W'(1000);

			trig_s4 <= trig_s3;
			done_s4 <= done_s3;
			mm_s4   <= mm_s3;
			thou_s4 <= thou_s3;
			hund_s4 <= hund_c;
			rem_s4  <= rem_s3 - DIST_W'(hund_c) * DIST_W'(100);
		end
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= rec_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (adv && valid_s4) begin
			out_trig_q     <= trig_s4;
			out_done_q     <= done_s4;
			out_enable_n_q <= ~(DIGITS'(1) << scan_q);
			out_seg_q      <= seg_decode(shown);
			out_dist_q     <= done_s4 ? mm_s4 : dist_q;
		end
	end

	// display state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			dist_q      <= '0;
			scan_q      <= '0;
			dwell_cnt_q <= '0;
			for (int i = 0; i < DIGITS; i++) begin
				digit_q[i] <= '0;
			end
		end else if (adv) begin
			out_valid_q <= valid_s4;
			if (valid_s4) begin
				if (done_s4) begin
					dist_q <= mm_s4;
					for (int i = 0; i < DIGITS; i++) begin
						digit_q[i] <= new_digit[i];
					end
				end
				if (dwell_wrap) begin
					dwell_cnt_q <= '0;
					scan_q      <= scan_q + SCAN_W'(1);
				end else begin
					dwell_cnt_q <= dwell_inc;
				end
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_trig     = out_trig_q;
	assign out_done     = out_done_q;
	assign out_enable_n = out_enable_n_q;
	assign out_seg      = out_seg_q;
	assign out_dist     = out_dist_q;

	// exactly one digit lit on every word
	a_one_digit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot(~out_enable_n_q))
		else $error("digit enables not one-hot");

	// decimal point never driven
	a_dp_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_seg_q[SEG_W-1] == 1'b0))
		else $error("decimal point driven");

	// converted distance stays within the clamp
	a_dist_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (mm_s2 <= MAX_MM))
		else $error("distance above clamp");

endmodule
